// File: sv/cqpg_pkg.sv
package cqpg_pkg;

  localparam int unsigned CRD_W = 32;
  localparam int unsigned WGT_W = 48;

  // input word kinds
  localparam logic [1:0] REQ_CELL  = 2'd0;
  localparam logic [1:0] REQ_FACE  = 2'd1;
  localparam logic [1:0] REQ_NODE0 = 2'd2;
  localparam logic [1:0] REQ_NODE1 = 2'd3;

  // configuration register indexes
  localparam logic CFG_DEGREE = 1'b0;
  localparam logic CFG_DIMS   = 1'b1;

  // tet rule: a and (1-3a) - a in Q0.16
  localparam logic signed [32:0] A_Q16  = 33'sd9057;
  localparam logic signed [32:0] BA_Q16 = 33'sd29308;
  // weight = floor(|det| >> shift) / 3; /6 and /24 fold their power of two into the shift
  localparam int unsigned        TRI_SHIFT = 17;
  localparam int unsigned        TET_SHIFT = 35;
  // ceil(2^19 / 3): exact floor(v / 3) for v below 2^18
  localparam logic [17:0]        RECIP3  = 18'd174763;
  localparam logic [47:0]        W_MAX   = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    JOB_CENT = 3'b001,
    JOB_TRI  = 3'b010,
    JOB_TET  = 3'b100
  } job_kind_t;

  // v holds centroid, face centroid, node0, node1; three coordinates each
  typedef struct packed {
    job_kind_t         kind;
    logic [11:0][31:0] v;
    logic [47:0]       vol;
  } job_t;

endpackage

// File: sv/cqpg_in_if.sv
interface cqpg_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  logic [47:0]        cell_volume;

  modport source(output valid, req_type, coord_x, coord_y, coord_z, cell_volume,
                 input ready);
  modport sink(input valid, req_type, coord_x, coord_y, coord_z, cell_volume,
               output ready);
endinterface

// File: sv/cqpg_out_if.sv
interface cqpg_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic [47:0]        point_weight;
  logic [1:0]         sub_point;
  logic               last_point;

  modport source(output valid, point_x, point_y, point_z, point_weight, sub_point,
                 last_point, input ready);
  modport sink(input valid, point_x, point_y, point_z, point_weight, sub_point,
               last_point, output ready);
endinterface

// File: sv/cqpg_front.sv
module cqpg_front #(
  parameter int COORD_BITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  cqpg_in_if.sink         in_ch,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [1:0]      cfg_wdata,
  input  logic            q_full,
  output logic            job_push,
  output cqpg_pkg::job_t  job
);

  localparam int Cw = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam int Sh = 32 - Cw;

  logic             degree_r;
  logic [1:0]       dims_r;
  logic [2:0][31:0] cc_r, fc_r, n0_r;
  logic [2:0][31:0] p;
  logic [1:0]       dims_eff;
  logic             one_pt;
  logic             accept;

  function automatic logic [31:0] sx(input logic [31:0] a);
    logic [31:0] t;
    t  = a << Sh;
    sx = 32'($signed(t) >>> Sh);
  endfunction

  assign dims_eff    = (dims_r == 2'd0) ? 2'd1 : dims_r;
  assign one_pt      = !degree_r || (dims_eff == 2'd1);
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    p[0] = sx(in_ch.coord_x);
    p[1] = (dims_eff >= 2'd2) ? sx(in_ch.coord_y) : 32'd0;
    p[2] = (dims_eff == 2'd3) ? sx(in_ch.coord_z) : 32'd0;
  end

  always_comb begin
    job.v   = {p, n0_r, fc_r, (in_ch.req_type == cqpg_pkg::REQ_CELL) ? p : cc_r};
    job.vol = in_ch.cell_volume;
    if (in_ch.req_type == cqpg_pkg::REQ_CELL) begin
      job.kind = cqpg_pkg::JOB_CENT;
    end else if (dims_eff == 2'd2) begin
      job.kind = cqpg_pkg::JOB_TRI;
    end else begin
      job.kind = cqpg_pkg::JOB_TET;
    end
  end

  assign job_push = accept &&
                    (((in_ch.req_type == cqpg_pkg::REQ_CELL) && one_pt) ||
                     ((in_ch.req_type == cqpg_pkg::REQ_NODE1) && !one_pt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= 1'b0;
      dims_r   <= 2'd3;
      cc_r     <= '0;
      fc_r     <= '0;
      n0_r     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          cqpg_pkg::CFG_DEGREE: degree_r <= cfg_wdata[0];
          cqpg_pkg::CFG_DIMS:   dims_r   <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        unique case (in_ch.req_type)
          cqpg_pkg::REQ_CELL:  cc_r <= p;
          cqpg_pkg::REQ_FACE:  fc_r <= p;
          cqpg_pkg::REQ_NODE0: n0_r <= p;
          default: ;
        endcase
      end
    end
  end

endmodule

// File: sv/cqpg_queue.sv
module cqpg_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cqpg_pkg::job_t din,
  output logic           full,
  input  logic           pop,
  output cqpg_pkg::job_t dout,
  output logic           valid
);

  cqpg_pkg::job_t mem_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: sv/cqpg_back.sv
module cqpg_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  cqpg_pkg::job_t q_job,
  output logic           q_pop,
  cqpg_out_if.source     out_ch
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PREP  = 7'b0000010,
    ST_MUL   = 7'b0000100,
    ST_DRAIN = 7'b0001000,
    ST_DIVI  = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  state_t              state_r;
  cqpg_pkg::job_t      job_r;
  logic [4:0]          stp_r, pstp_r, last_stp;
  logic                pv_r;
  logic signed [67:0]  prod_r;
  logic signed [32:0]  ua_r [3];
  logic signed [32:0]  ub_r [3];
  logic signed [32:0]  uc_r [3];
  logic signed [33:0]  s_r [3];
  logic signed [67:0]  m_r [3];
  logic signed [55:0]  as_r [3];
  logic signed [103:0] det_r;
  logic [3:0][2:0][31:0] q_r;
  logic [47:0]         dd_r, w_r;
  logic [31:0]         quo_r;
  logic [1:0]          rem_r;
  logic                sat_r;
  logic [1:0]          cnt_r;
  logic [1:0]          e_r, n_last;
  logic                is_tri;

  logic signed [34:0]  x_op;
  logic signed [32:0]  y_op;
  logic [3:0]          jx, jc, jm;

  logic [103:0]        mag;
  logic [71:0]         dvd;
  logic [17:0]         dchunk, dr;
  logic [35:0]         dprod;
  logic [15:0]         dq;
  logic signed [55:0]  qsum;

  logic                ov_r, ld;
  logic [31:0]         ox_r, oy_r, oz_r, px, py, pz;
  logic [47:0]         ow_r;
  logic [1:0]          osub_r;
  logic                olast_r;

  function automatic logic signed [32:0] d33(input logic [31:0] a, input logic [31:0] b);
    d33 = 33'($signed(a)) - 33'($signed(b));
  endfunction

  function automatic logic [31:0] mid(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] t;
    t   = 33'($signed(a)) + 33'($signed(b));
    mid = t[32:1];
  endfunction

  // tet point slot -> {point, coordinate}
  function automatic logic [3:0] jmap(input logic [3:0] j);
    case (j)
      4'd0:    jmap = {2'd0, 2'd0};
      4'd1:    jmap = {2'd0, 2'd1};
      4'd2:    jmap = {2'd0, 2'd2};
      4'd3:    jmap = {2'd1, 2'd0};
      4'd4:    jmap = {2'd1, 2'd1};
      4'd5:    jmap = {2'd1, 2'd2};
      4'd6:    jmap = {2'd2, 2'd0};
      4'd7:    jmap = {2'd2, 2'd1};
      4'd8:    jmap = {2'd2, 2'd2};
      4'd9:    jmap = {2'd3, 2'd0};
      4'd10:   jmap = {2'd3, 2'd1};
      4'd11:   jmap = {2'd3, 2'd2};
      default: jmap = 4'd0;
    endcase
  endfunction

  assign is_tri   = (job_r.kind == cqpg_pkg::JOB_TRI);
  assign last_stp = is_tri ? 5'd1 : 5'd26;
  assign q_pop    = (state_r == ST_IDLE) && q_valid;

  // operand select for the shared multiplier
  always_comb begin
    x_op = '0;
    y_op = '0;
    jx   = 4'(stp_r - 5'd15);
    if (is_tri) begin
      case (stp_r)
        5'd0: begin x_op = 35'(ua_r[0]); y_op = ub_r[1]; end
        5'd1: begin x_op = 35'(ua_r[1]); y_op = ub_r[0]; end
        default: ;
      endcase
    end else begin
      case (stp_r)
        5'd0:  begin x_op = 35'(ub_r[1]); y_op = uc_r[2]; end
        5'd1:  begin x_op = 35'(uc_r[1]); y_op = ub_r[2]; end
        5'd2:  begin x_op = 35'(ub_r[0]); y_op = uc_r[2]; end
        5'd3:  begin x_op = 35'(uc_r[0]); y_op = ub_r[2]; end
        5'd4:  begin x_op = 35'(ub_r[0]); y_op = uc_r[1]; end
        5'd5:  begin x_op = 35'(uc_r[0]); y_op = ub_r[1]; end
        5'd6:  begin x_op = $signed({1'b0, m_r[0][33:0]}); y_op = ua_r[0]; end
        5'd7:  begin x_op = 35'($signed(m_r[0][67:34])); y_op = ua_r[0]; end
        5'd8:  begin x_op = $signed({1'b0, m_r[1][33:0]}); y_op = ua_r[1]; end
        5'd9:  begin x_op = 35'($signed(m_r[1][67:34])); y_op = ua_r[1]; end
        5'd10: begin x_op = $signed({1'b0, m_r[2][33:0]}); y_op = ua_r[2]; end
        5'd11: begin x_op = 35'($signed(m_r[2][67:34])); y_op = ua_r[2]; end
        5'd12: begin x_op = 35'(s_r[0]); y_op = cqpg_pkg::A_Q16; end
        5'd13: begin x_op = 35'(s_r[1]); y_op = cqpg_pkg::A_Q16; end
        5'd14: begin x_op = 35'(s_r[2]); y_op = cqpg_pkg::A_Q16; end
        default: begin
          x_op = 35'($signed(job_r.v[jx]));
          y_op = cqpg_pkg::BA_Q16;
        end
      endcase
    end
  end

  always_comb begin
    jc   = 4'(pstp_r - 5'd15);
    jm   = jmap(jc);
    qsum = as_r[jm[1:0]] + 56'(prod_r) + 56'sd32768;
  end

  // weight divide by 3, one 16-bit digit per cycle through a reciprocal multiply
  always_comb begin
    mag    = det_r[103] ? 104'(-det_r) : 104'(det_r);
    dvd    = is_tri ? 72'(mag >> cqpg_pkg::TRI_SHIFT) : 72'(mag >> cqpg_pkg::TET_SHIFT);
    dchunk = {rem_r, dd_r[47:32]};
    dprod  = dchunk * cqpg_pkg::RECIP3;
    dq     = dprod[34:19];
    dr     = dchunk - ({1'b0, dq, 1'b0} + {2'b0, dq});
  end

  always_comb begin
    px = '0;
    py = '0;
    pz = '0;
    n_last = 2'd0;
    case (job_r.kind)
      cqpg_pkg::JOB_CENT: begin
        px = job_r.v[0]; py = job_r.v[1]; pz = job_r.v[2];
      end
      cqpg_pkg::JOB_TRI: begin
        n_last = 2'd2;
        case (e_r)
          2'd0:    begin px = job_r.v[3]; py = job_r.v[4]; end
          2'd1:    begin px = mid(job_r.v[6], job_r.v[0]); py = mid(job_r.v[7], job_r.v[1]); end
          default: begin px = mid(job_r.v[9], job_r.v[0]); py = mid(job_r.v[10], job_r.v[1]); end
        endcase
      end
      default: begin
        n_last = 2'd3;
        px = q_r[e_r][0]; py = q_r[e_r][1]; pz = q_r[e_r][2];
      end
    endcase
  end

  assign ld = (state_r == ST_EMIT) && (!ov_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pv_r    <= 1'b0;
    end else begin
      pv_r <= (state_r == ST_MUL);
      unique case (state_r)
        ST_IDLE: if (q_valid) begin
          state_r <= (q_job.kind == cqpg_pkg::JOB_CENT) ? ST_EMIT : ST_PREP;
        end
        ST_PREP:  state_r <= ST_MUL;
        ST_MUL:   if (stp_r == last_stp) state_r <= ST_DRAIN;
        ST_DRAIN: state_r <= ST_DIVI;
        ST_DIVI:  state_r <= ST_DIV;
        ST_DIV:   if (cnt_r == 2'd2) state_r <= ST_EMIT;
        ST_EMIT:  if (ld && (e_r == n_last)) state_r <= ST_IDLE;
        default:  state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= x_op * y_op;
    pstp_r <= stp_r;
    unique case (state_r)
      ST_IDLE: begin
        job_r <= q_job;
        w_r   <= q_job.vol;
        e_r   <= 2'd0;
      end
      ST_PREP: begin
        stp_r   <= 5'd0;
        ua_r[0] <= is_tri ? d33(job_r.v[9], job_r.v[6]) : d33(job_r.v[3], job_r.v[0]);
        ua_r[1] <= is_tri ? d33(job_r.v[10], job_r.v[7]) : d33(job_r.v[4], job_r.v[1]);
        ua_r[2] <= d33(job_r.v[5], job_r.v[2]);
        ub_r[0] <= is_tri ? d33(job_r.v[0], job_r.v[6]) : d33(job_r.v[6], job_r.v[0]);
        ub_r[1] <= is_tri ? d33(job_r.v[1], job_r.v[7]) : d33(job_r.v[7], job_r.v[1]);
        ub_r[2] <= d33(job_r.v[8], job_r.v[2]);
        for (int i = 0; i < 3; i++) begin
          uc_r[i] <= d33(job_r.v[9+i], job_r.v[i]);
          s_r[i]  <= 34'($signed(job_r.v[i])) + 34'($signed(job_r.v[3+i])) +
                     34'($signed(job_r.v[6+i])) + 34'($signed(job_r.v[9+i]));
        end
      end
      ST_MUL: stp_r <= stp_r + 5'd1;
      ST_DIVI: begin
        // quotient needs more than 48 bits
        sat_r <= (dvd[71:48] >= 24'd3);
        rem_r <= dvd[49:48];
        dd_r  <= dvd[47:0];
        cnt_r <= 2'd0;
      end
      ST_DIV: begin
        rem_r <= dr[1:0];
        quo_r <= {quo_r[15:0], dq};
        dd_r  <= dd_r << 16;
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd2) w_r <= sat_r ? cqpg_pkg::W_MAX : {quo_r, dq};
      end
      ST_EMIT: if (ld) e_r <= e_r + 2'd1;
      default: ;
    endcase

    // retire the product issued last cycle
    if (pv_r) begin
      if (is_tri) begin
        if (pstp_r == 5'd0) det_r <= 104'(prod_r);
        else                det_r <= det_r - 104'(prod_r);
      end else begin
        case (pstp_r)
          5'd0:  m_r[0] <= prod_r;
          5'd1:  m_r[0] <= m_r[0] - prod_r;
          5'd2:  m_r[1] <= prod_r;
          5'd3:  m_r[1] <= m_r[1] - prod_r;
          5'd4:  m_r[2] <= prod_r;
          5'd5:  m_r[2] <= m_r[2] - prod_r;
          5'd6:  det_r <= 104'(prod_r);
          5'd7:  det_r <= det_r + (104'(prod_r) <<< 34);
          5'd8:  det_r <= det_r - 104'(prod_r);
          5'd9:  det_r <= det_r - (104'(prod_r) <<< 34);
          5'd10: det_r <= det_r + 104'(prod_r);
          5'd11: det_r <= det_r + (104'(prod_r) <<< 34);
          5'd12: as_r[0] <= 56'(prod_r);
          5'd13: as_r[1] <= 56'(prod_r);
          5'd14: as_r[2] <= 56'(prod_r);
          default: q_r[jm[3:2]][jm[1:0]] <= qsum[47:16];
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (ld) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      ox_r    <= px;
      oy_r    <= py;
      oz_r    <= pz;
      ow_r    <= w_r;
      osub_r  <= e_r;
      olast_r <= (e_r == n_last);
    end
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.point_x      = ox_r;
  assign out_ch.point_y      = oy_r;
  assign out_ch.point_z      = oz_r;
  assign out_ch.point_weight = ow_r;
  assign out_ch.sub_point    = osub_r;
  assign out_ch.last_point   = olast_r;

endmodule

// File: sv/cell_quadrature_point_generator.sv
// channel   dir  handshake       payload
// in_ch     in   valid/ready     req_type, coord_x/y/z, cell_volume
// out_ch    out  valid/ready     point_x/y/z, point_weight, sub_point, last_point
// cfg       in   cfg_we          cfg_index, cfg_wdata
//
// store-only words are taken while the queue is not full and push no job; a one-point
// centroid word is pushed into the two-entry job queue, popped by the idle back end and
// sent out through the emit state. from pop back to idle a triangle or tetrahedron passes
// prep, 2 or 27 products through the shared 35x33 multiplier, a drain, a divide setup,
// a weight divide by 3 in 16-bit digits, then its points, one per cycle while ready is high.
// rst_n is synchronous; it clears the stores, the queue and the sequencer.
// the front keeps taking words while the back works, until the queue is full.
module cell_quadrature_point_generator #(
  parameter int COORD_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  cqpg_in_if.sink    in_ch,
  cqpg_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [1:0] cfg_wdata
);

  cqpg_pkg::job_t f_job, q_job;
  logic           q_push, q_full, q_pop, q_valid;

  cqpg_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .q_full(q_full), .job_push(q_push), .job(f_job)
  );

  cqpg_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .din(f_job), .full(q_full),
    .pop(q_pop), .dout(q_job), .valid(q_valid)
  );

  cqpg_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_job(q_job), .q_pop(q_pop),
    .out_ch(out_ch)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("job queue underflow");

  a_last_sub: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.last_point) |-> (out_ch.sub_point != 2'd3))
    else $error("fourth point not marked last");

endmodule
